### hw/rtl/dks_pkg.sv
// DES key schedule package: permutation tables, rotation schedule and helpers.
`timescale 1ns / 1ps
package dks_pkg;

  localparam int unsigned KeyW    = 64;
  localparam int unsigned CdW     = 56;
  localparam int unsigned HalfW   = 28;
  localparam int unsigned SubkeyW = 48;
  localparam int unsigned RoundW  = 4;

  localparam logic [RoundW-1:0] LastRound = 4'd15;

  // Bit r set: round r rotates by two, else by one.
  localparam logic [15:0] RotTwoMask = 16'h7EFC;

  // Positions numbered from 1 at the most significant bit.
  localparam logic [6:0] Pc1Tab [CdW] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34,
    7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
    7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] Pc2Tab [SubkeyW] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // Word moved from front to back: the C/D register pair after PC1.
  typedef struct packed {
    logic           valid;
    logic [CdW-1:0] cd;
  } cd_word_t;

  function automatic logic [CdW-1:0] pc1(input logic [KeyW-1:0] key);
    logic [CdW-1:0] acc;
    for (int i = 0; i < CdW; i++) begin
      acc[CdW-1-i] = key[6'(7'd64 - Pc1Tab[i])];
    end
    return acc;
  endfunction

  function automatic logic [SubkeyW-1:0] pc2(input logic [CdW-1:0] cd);
    logic [SubkeyW-1:0] acc;
    for (int i = 0; i < SubkeyW; i++) begin
      acc[SubkeyW-1-i] = cd[6'(6'd56 - Pc2Tab[i])];
    end
    return acc;
  endfunction

  function automatic logic [HalfW-1:0] rotl_half(input logic [HalfW-1:0] h,
                                                 input logic two);
    return two ? {h[HalfW-3:0], h[HalfW-1:HalfW-2]} : {h[HalfW-2:0], h[HalfW-1]};
  endfunction

endpackage

### hw/rtl/dks_front.sv
// Front end: takes key words, applies PC1 and hands C/D words to the queue.
`timescale 1ns / 1ps
module dks_front import dks_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [KeyW-1:0] key_i,
  output cd_word_t        push_o,
  input  logic            push_ready_i
);

  logic           valid_q, valid_d;
  logic [CdW-1:0] cd_q;
  logic           accept;

  assign in_stall_o = valid_q && !push_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cd_q <= pc1(key_i);
    end
  end

  assign push_o.valid = valid_q;
  assign push_o.cd    = cd_q;

endmodule

### hw/rtl/dks_queue.sv
// Short FIFO of C/D words between front and back.
`timescale 1ns / 1ps
module dks_queue import dks_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cd_word_t push_i,
  output logic     push_ready_o,
  output cd_word_t pop_o,
  input  logic     pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  logic [CdW-1:0]  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign do_push      = push_i.valid && push_ready_o;
  assign do_pop       = pop_i && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.cd;
    end
  end

  assign pop_o.valid = (count_q != '0);
  assign pop_o.cd    = mem_q[rd_ptr_q];

endmodule

### hw/rtl/dks_back.sv
// Back end: one round per cycle unless stalled: C/D rotate, PC2 to output register.
`timescale 1ns / 1ps
module dks_back import dks_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cd_word_t           pop_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [RoundW-1:0]  round_index_o,
  output logic [SubkeyW-1:0] subkey_o,
  output logic               last_o
);

  logic                busy_q, busy_d;
  logic [RoundW-1:0]   round_q;
  logic [CdW-1:0]      cd_q, cd_next;
  logic                out_valid_q, out_valid_d;
  logic [RoundW-1:0]   out_round_q;
  logic [SubkeyW-1:0]  out_subkey_q;
  logic                out_last_q;
  logic                adv, at_last, two;

  assign two     = RotTwoMask[round_q];
  assign cd_next = {rotl_half(cd_q[CdW-1:HalfW], two), rotl_half(cd_q[HalfW-1:0], two)};
  assign at_last = (round_q == LastRound);
  assign adv     = busy_q && (!out_valid_q || !out_stall_i);
  // Next key is loaded as the final round issues, so keys run back to back.
  assign pop_o   = pop_i.valid && (!busy_q || (adv && at_last));

  always_comb begin
    busy_d = busy_q;
    if (pop_o) begin
      busy_d = 1'b1;
    end else if (adv && at_last) begin
      busy_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      round_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        round_q <= '0;
      end else if (adv) begin
        round_q <= round_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cd_q <= pop_i.cd;
    end else if (adv) begin
      cd_q <= cd_next;
    end
    if (adv) begin
      out_round_q  <= round_q;
      out_subkey_q <= pc2(cd_next);
      out_last_q   <= at_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign round_index_o = out_round_q;
  assign subkey_o      = out_subkey_q;
  assign last_o        = out_last_q;

endmodule

### hw/rtl/des_key_schedule.sv
// DES key schedule top level: front end, C/D queue and round sequencer.
`timescale 1ns / 1ps
// Each 64-bit key word accepted on the input yields sixteen subkey words, in
// round order, each with its zero-based round number and a last flag on round
// fifteen. PC1 is applied in the front end; the back end produces one subkey per
// cycle unless the output stalls, and keys run back to back. A key goes through
// the front register, the queue and the C/D register before its subkeys reach
// the output register. The front end keeps taking keys while the sequencer is
// busy, up to QueueDepth queued plus one held in the front register.
module des_key_schedule import dks_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [KeyW-1:0]    key_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [RoundW-1:0]  round_index_o,
  output logic [SubkeyW-1:0] subkey_o,
  output logic               last_o
);

  cd_word_t push_w, pop_w;
  logic     push_ready, pop;

  dks_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .key_i       (key_i),
    .push_o      (push_w),
    .push_ready_i(push_ready)
  );

  dks_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_w),
    .push_ready_o(push_ready),
    .pop_o       (pop_w),
    .pop_i       (pop)
  );

  dks_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_i        (pop_w),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .round_index_o(round_index_o),
    .subkey_o     (subkey_o),
    .last_o       (last_o)
  );

endmodule
